// File: rtl/ttcs_pkg.sv
// Shared widths, reset values and register indexes of the console scroller.
package ttcs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 256;
  localparam int unsigned MAX_LINE        = 48;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned PITCH_W  = 8;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COL_W-1:0]   LINE_LENGTH_RST  = 6'd40;
  localparam logic [PITCH_W-1:0] SCROLL_PITCH_RST = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH  = 2'd0,
    REG_SCROLL_PITCH = 2'd1,
    REG_PRINT_TICKS  = 2'd2,
    REG_SCROLL_TICKS = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_TIME = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

endpackage

// File: rtl/ttcs_if.sv
// Valid/ready channel interfaces for request items and result items.
interface ttcs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [ttcs_pkg::CHAR_W-1:0]    char_code;
  logic [ttcs_pkg::TICK_W-1:0]    now_ticks;

  modport source (output valid, output req_type, output char_code, output now_ticks,
                  input ready);
  modport sink   (input valid, input req_type, input char_code, input now_ticks,
                  output ready);
endinterface

interface ttcs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic        [ttcs_pkg::CHAR_W-1:0]   out_char;
  logic        [ttcs_pkg::COL_W-1:0]    column;
  logic signed [ttcs_pkg::OFFSET_W-1:0] offset_now;
  logic                                line_rotated;
  logic                                scroll_active;
  logic                                dropped;
  logic                                last;

  modport source (output valid, output kind, output out_char, output column,
                  output offset_now, output line_rotated, output scroll_active,
                  output dropped, output last, input ready);
  modport sink   (input valid, input kind, input out_char, input column,
                  input offset_now, input line_rotated, input scroll_active,
                  input dropped, input last, output ready);
endinterface

// File: rtl/timed_text_console_scroller_core.sv
// Top level: character queue and tick-spending sequencer of the text console.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-----------------------------------------------
//  in_i     | in  | valid/ready  | req_type, char_code, now_ticks
//  out_o    | out | valid/ready  | kind, out_char, column, offset_now,
//           |     |              | line_rotated, scroll_active, dropped, last
//  cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
//  A push waits for out_o.ready to take its status result. A time update
//  is lengthened by each scrolled pixel or rotation and each printed
//  character, plus output stalls; one 32-bit subtractor is stepped by the
//  sequencer and each printed character costs one registered queue read.
//  in_i.ready is high only while the sequencer is idle and no result is held.
//  Reset (rst_ni low, asynchronous) empties the queue and clears the scroll
//  state; the queue storage itself is not cleared.
module timed_text_console_scroller_core #(
  parameter int unsigned QUEUE_DEPTH = ttcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ttcs_in_if.sink                             in_i,
  ttcs_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttcs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW   = ttcs_pkg::TICK_W;
  localparam int unsigned OW   = ttcs_pkg::OFFSET_W;
  localparam int unsigned CW   = ttcs_pkg::COL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_READ,
    S_FIN,
    S_OUT
  } state_e;

  // configuration registers
  logic [CW-1:0]                    line_length_q;
  logic [ttcs_pkg::PITCH_W-1:0]     scroll_pitch_q;
  logic [TW-1:0]                    print_ticks_q;
  logic [TW-1:0]                    scroll_ticks_q;

  // sequencer state
  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic [PtrW-1:0]        head_q;
  logic [PtrW-1:0]        tail_q;
  logic [CW-1:0]          col_q;
  logic signed [OW-1:0]   offset_q;
  logic                   scroll_q;
  logic [TW-1:0]          saved_q;
  logic [TW-1:0]          ticks_q;
  logic [TW-1:0]          now_q;
  logic                   rot_q;
  logic                   full_q;
  logic [CW-1:0]          col_out_q;

  // result register
  logic                          out_valid_q;
  logic                          out_kind_q;
  logic [ttcs_pkg::CHAR_W-1:0]   out_char_q;
  logic [CW-1:0]                 out_col_q;
  logic signed [OW-1:0]          out_off_q;
  logic                          out_rot_q;
  logic                          out_act_q;
  logic                          out_drop_q;
  logic                          out_last_q;

  // queue storage
  logic [ttcs_pkg::CHAR_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [ttcs_pkg::CHAR_W-1:0] rd_data_q;

  logic                   in_take;
  logic                   out_take;
  logic                   is_push;
  logic                   q_full;
  logic                   mem_we;
  logic                   mem_re;
  logic [TW-1:0]          sub_a;
  logic [TW-1:0]          sub_b;
  logic [TW:0]            sub_res;
  logic                   ticks_ge;
  logic [CW-1:0]          len_eff;
  logic [ttcs_pkg::PITCH_W-1:0] pitch_eff;
  logic signed [OW-1:0]   end_off;
  logic                   at_end;
  logic                   line_full;
  logic                   can_print;

  assign in_take  = in_i.valid && in_i.ready;
  assign out_take = out_o.valid && out_o.ready;
  assign is_push  = (in_i.req_type == ttcs_pkg::REQ_PUSH);
  assign q_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign mem_we   = in_take && is_push && !q_full;

  // line length limited to 1..48, pitch zero acts as one
  always_comb begin
    priority if (line_length_q == '0) begin
      len_eff = CW'(1);
    end else if (line_length_q > CW'(ttcs_pkg::MAX_LINE)) begin
      len_eff = CW'(ttcs_pkg::MAX_LINE);
    end else begin
      len_eff = line_length_q;
    end
  end

  assign pitch_eff = (scroll_pitch_q == '0) ? 8'd1 : scroll_pitch_q;
  assign end_off   = $signed(OW'(1) - {1'b0, pitch_eff});
  assign at_end    = (offset_q <= end_off);
  assign line_full = ({1'b0, col_q} + 7'd1) >= {1'b0, len_eff};
  assign can_print = (count_q != '0) && ticks_ge;

  // shared subtractor: elapsed ticks, tick charge, or saved time
  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        sub_a = in_i.now_ticks;
        sub_b = saved_q;
      end
      S_FIN: begin
        sub_a = now_q;
        sub_b = ticks_q;
      end
      default: begin
        sub_a = ticks_q;
        sub_b = scroll_q ? scroll_ticks_q : print_ticks_q;
      end
    endcase
  end

  assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ticks_ge = !sub_res[TW];

  assign mem_re = (state_q == S_STEP) && !scroll_q && can_print;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[tail_q] <= in_i.char_code;
    end
    if (mem_re) begin
      rd_data_q <= queue_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q  <= ttcs_pkg::LINE_LENGTH_RST;
      scroll_pitch_q <= ttcs_pkg::SCROLL_PITCH_RST;
      print_ticks_q  <= '0;
      scroll_ticks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ttcs_pkg::reg_idx_e'(cfg_idx_i))
        ttcs_pkg::REG_LINE_LENGTH:  line_length_q  <= cfg_wdata_i[CW-1:0];
        ttcs_pkg::REG_SCROLL_PITCH: scroll_pitch_q <= cfg_wdata_i[ttcs_pkg::PITCH_W-1:0];
        ttcs_pkg::REG_PRINT_TICKS:  print_ticks_q  <= cfg_wdata_i[TW-1:0];
        ttcs_pkg::REG_SCROLL_TICKS: scroll_ticks_q <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      col_q       <= '0;
      offset_q    <= '0;
      scroll_q    <= 1'b0;
      saved_q     <= '0;
      ticks_q     <= '0;
      now_q       <= '0;
      rot_q       <= 1'b0;
      full_q      <= 1'b0;
      col_out_q   <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= ttcs_pkg::KIND_STATUS;
      out_char_q  <= '0;
      out_col_q   <= '0;
      out_off_q   <= '0;
      out_rot_q   <= 1'b0;
      out_act_q   <= 1'b0;
      out_drop_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            if (is_push) begin
              if (!q_full) begin
                tail_q  <= (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
                count_q <= count_q + CntW'(1);
              end
              out_valid_q <= 1'b1;
              out_kind_q  <= ttcs_pkg::KIND_STATUS;
              out_char_q  <= '0;
              out_col_q   <= '0;
              out_off_q   <= offset_q;
              out_rot_q   <= 1'b0;
              out_act_q   <= scroll_q;
              out_drop_q  <= q_full;
              out_last_q  <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              ticks_q <= sub_res[TW-1:0];
              now_q   <= in_i.now_ticks;
              rot_q   <= 1'b0;
              full_q  <= 1'b0;
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (scroll_q) begin
            priority if (!ticks_ge) begin
              state_q <= S_FIN;
            end else if (at_end) begin
              // rotate without charge, then try to print
              offset_q <= '0;
              rot_q    <= 1'b1;
              scroll_q <= 1'b0;
            end else begin
              offset_q <= offset_q - OW'(1);
              ticks_q  <= sub_res[TW-1:0];
            end
          end else if (can_print) begin
            head_q    <= (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
            count_q   <= count_q - CntW'(1);
            ticks_q   <= sub_res[TW-1:0];
            col_out_q <= col_q;
            if (line_full) begin
              col_q    <= '0;
              scroll_q <= 1'b1;
              full_q   <= 1'b1;
            end else begin
              col_q    <= col_q + CW'(1);
            end
            state_q <= S_READ;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          out_kind_q  <= ttcs_pkg::KIND_CHAR;
          out_char_q  <= rd_data_q;
          out_col_q   <= col_out_q;
          out_off_q   <= '0;
          out_rot_q   <= 1'b0;
          out_act_q   <= 1'b0;
          out_drop_q  <= 1'b0;
          out_last_q  <= 1'b0;
          state_q     <= S_OUT;
        end
        S_FIN: begin
          // carry unspent ticks into the saved time
          saved_q     <= sub_res[TW-1:0];
          out_valid_q <= 1'b1;
          out_kind_q  <= ttcs_pkg::KIND_STATUS;
          out_char_q  <= '0;
          out_col_q   <= '0;
          out_off_q   <= offset_q;
          out_rot_q   <= rot_q;
          out_act_q   <= scroll_q;
          out_drop_q  <= 1'b0;
          out_last_q  <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_take) begin
            out_valid_q <= 1'b0;
            priority if (out_last_q) begin
              state_q <= S_IDLE;
            end else if (full_q) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.column        = out_col_q;
  assign out_o.offset_now    = out_off_q;
  assign out_o.line_rotated  = out_rot_q;
  assign out_o.scroll_active = out_act_q;
  assign out_o.dropped       = out_drop_q;
  assign out_o.last          = out_last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_offset_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= 0)
    else $error("scroll offset positive");

  a_char_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == ttcs_pkg::KIND_CHAR)
      |-> (out_o.column < CW'(ttcs_pkg::MAX_LINE) && !out_o.last))
    else $error("character item with bad column or end mark");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && out_o.last) |=> in_i.ready)
    else $error("not ready after final result");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed text console scroller core.

typedef struct packed {
  ttcs_pkg::kind_e                kind;
  logic [ttcs_pkg::CHAR_W-1:0]    out_char;
  logic [ttcs_pkg::COL_W-1:0]     column;
  logic [ttcs_pkg::OFFSET_W-1:0]  offset_now;
  logic                           line_rotated;
  logic                           scroll_active;
  logic                           dropped;
  logic                           last;
} console_result_t;

class console_scoreboard;
  logic [ttcs_pkg::COL_W-1:0]   line_length  = ttcs_pkg::LINE_LENGTH_RST;
  logic [ttcs_pkg::PITCH_W-1:0] scroll_pitch = ttcs_pkg::SCROLL_PITCH_RST;
  logic [ttcs_pkg::TICK_W-1:0]  print_ticks  = '0;
  logic [ttcs_pkg::TICK_W-1:0]  scroll_ticks = '0;

  logic [ttcs_pkg::CHAR_W-1:0]  held_chars[$];
  int unsigned                  write_column = 0;
  int                           pixel_offset = 0;
  bit                           scrolling    = 1'b0;
  logic [ttcs_pkg::TICK_W-1:0]  saved_time   = '0;

  console_result_t              due_results[$];
  int                           failures = 0;

  function void write_reg(ttcs_pkg::reg_idx_e idx, logic [ttcs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ttcs_pkg::REG_LINE_LENGTH:  line_length  = data[ttcs_pkg::COL_W-1:0];
      ttcs_pkg::REG_SCROLL_PITCH: scroll_pitch = data[ttcs_pkg::PITCH_W-1:0];
      ttcs_pkg::REG_PRINT_TICKS:  print_ticks  = data[ttcs_pkg::TICK_W-1:0];
      ttcs_pkg::REG_SCROLL_TICKS: scroll_ticks = data[ttcs_pkg::TICK_W-1:0];
      default: ;
    endcase
  endfunction

  function void add_result(ttcs_pkg::kind_e kind, logic [ttcs_pkg::CHAR_W-1:0] ch,
                           int unsigned col, int off, bit rot, bit act, bit drop);
    console_result_t r;
    r.kind          = kind;
    r.out_char      = ch;
    r.column        = col[ttcs_pkg::COL_W-1:0];
    r.offset_now    = off[ttcs_pkg::OFFSET_W-1:0];
    r.line_rotated  = rot;
    r.scroll_active = act;
    r.dropped       = drop;
    r.last          = (kind == ttcs_pkg::KIND_STATUS);
    due_results.insert(due_results.size(), r);
  endfunction

  function void note_request(ttcs_pkg::req_type_e req, logic [ttcs_pkg::CHAR_W-1:0] ch,
                             logic [ttcs_pkg::TICK_W-1:0] now);
    logic [ttcs_pkg::TICK_W-1:0] ticks;
    logic [ttcs_pkg::CHAR_W-1:0] head_char;
    int unsigned                 len;
    int                          end_off;
    bit                          rotated;
    bit                          drop;
    if (req == ttcs_pkg::REQ_PUSH) begin
      drop = held_chars.size() >= ttcs_pkg::QUEUE_DEPTH_DEF;
      if (!drop) held_chars.insert(held_chars.size(), ch);
      add_result(ttcs_pkg::KIND_STATUS, '0, 0, pixel_offset, 1'b0, scrolling, drop);
      return;
    end
    ticks   = now - saved_time;
    len     = (line_length == 0) ? 1 :
              ((line_length > ttcs_pkg::MAX_LINE) ? ttcs_pkg::MAX_LINE : line_length);
    end_off = 1 - ((scroll_pitch == 0) ? 1 : int'(scroll_pitch));
    rotated = 1'b0;
    forever begin
      if (scrolling && ticks >= scroll_ticks) begin
        if (pixel_offset > end_off) begin
          pixel_offset--;
          ticks -= scroll_ticks;
          continue;
        end
        // rotation is free of charge
        pixel_offset = 0;
        rotated      = 1'b1;
        scrolling    = 1'b0;
      end else if (scrolling || held_chars.size() == 0 || ticks < print_ticks) begin
        break;
      end
      if (held_chars.size() > 0 && ticks >= print_ticks) begin
        head_char = held_chars[0];
        held_chars.delete(0);
        add_result(ttcs_pkg::KIND_CHAR, head_char, write_column, 0, 1'b0, 1'b0, 1'b0);
        write_column++;
        ticks -= print_ticks;
        if (write_column >= len) begin
          write_column = 0;
          scrolling    = 1'b1;
          break;
        end
      end
    end
    // carry unspent ticks into the next update
    saved_time = now - ticks;
    add_result(ttcs_pkg::KIND_STATUS, '0, 0, pixel_offset, rotated, scrolling, 1'b0);
  endfunction

  function string show(console_result_t r);
    return $sformatf("kind=%0d char=%02h col=%0d off=%0d rot=%0b act=%0b drop=%0b last=%0b",
                     r.kind, r.out_char, r.column, $signed(r.offset_now), r.line_rotated,
                     r.scroll_active, r.dropped, r.last);
  endfunction

  function void check_result(console_result_t got);
    console_result_t want;
    if (due_results.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result: %s", show(got));
      return;
    end
    want = due_results[0];
    due_results.delete(0);
    if (got.kind !== want.kind || got.out_char !== want.out_char ||
        got.column !== want.column || got.offset_now !== want.offset_now ||
        got.line_rotated !== want.line_rotated || got.scroll_active !== want.scroll_active ||
        got.dropped !== want.dropped || got.last !== want.last) begin
      failures++;
      if (failures <= 10) $display("mismatch: expected %s / got %s", show(want), show(got));
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_SLACK = 8;
  localparam int unsigned CharW  = ttcs_pkg::CHAR_W;
  localparam int unsigned ColW   = ttcs_pkg::COL_W;
  localparam int unsigned PitchW = ttcs_pkg::PITCH_W;
  localparam int unsigned TickW  = ttcs_pkg::TICK_W;
  localparam int unsigned DataW  = ttcs_pkg::CFG_DATA_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  ttcs_pkg::reg_idx_e    cfg_idx;
  logic [DataW-1:0]      cfg_wdata;

  int                    in_gap_max;
  int                    out_gap_max;
  int                    hold_cycles;
  int                    cycle_count = 0;
  logic [TickW-1:0]      clock_now;
  console_scoreboard     sb;

  ttcs_in_if  in_ch ();
  ttcs_out_if out_ch ();

  timed_text_console_scroller_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** timed_text_console_scroller_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus the long hold-off when requested.
  initial begin : result_sink
    int              gap;
    console_result_t got;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0 || hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.kind          = ttcs_pkg::kind_e'(out_ch.kind);
      got.out_char      = out_ch.out_char;
      got.column        = out_ch.column;
      got.offset_now    = out_ch.offset_now;
      got.line_rotated  = out_ch.line_rotated;
      got.scroll_active = out_ch.scroll_active;
      got.dropped       = out_ch.dropped;
      got.last          = out_ch.last;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  task automatic send_item(ttcs_pkg::req_type_e req, logic [CharW-1:0] ch,
                           logic [TickW-1:0] now);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.req_type  = req;
    in_ch.char_code = ch;
    in_ch.now_ticks = now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(req, ch, now);
    @(negedge clk);
  endtask

  // The field that the request does not use carries random bits.
  task automatic push_char(logic [CharW-1:0] ch);
    send_item(ttcs_pkg::REQ_PUSH, ch, $urandom);
  endtask

  task automatic time_update(logic [TickW-1:0] now);
    send_item(ttcs_pkg::REQ_TIME, CharW'($urandom), now);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic set_regs(logic [ColW-1:0] ll, logic [PitchW-1:0] pitch,
                          logic [TickW-1:0] pt, logic [TickW-1:0] st);
    logic [DataW-1:0] vals [4];
    logic [DataW-1:0] junk;
    wait_drained();
    // junk in the unused upper bits of the narrow registers
    junk    = $urandom;
    vals[0] = {junk[DataW-1:ColW], ll};
    junk    = $urandom;
    vals[1] = {junk[DataW-1:PitchW], pitch};
    vals[2] = pt;
    vals[3] = st;
    cfg_we = 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx   = ttcs_pkg::reg_idx_e'(i);
      cfg_wdata = vals[i];
      sb.write_reg(ttcs_pkg::reg_idx_e'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(int items, logic [ColW-1:0] ll, logic [PitchW-1:0] pitch,
                              logic [TickW-1:0] pt, logic [TickW-1:0] st);
    set_regs(ll, pitch, pt, st);
    in_gap_max  = $urandom_range(0, 1) * 5;
    out_gap_max = $urandom_range(0, 1) * 5;
    clock_now   = sb.saved_time;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) wait_drained();
      if ($urandom_range(0, 99) < 60) begin
        push_char(CharW'($urandom));
      end else begin
        // mostly advance time; now and then jump anywhere, backwards too
        if ($urandom_range(0, 9) == 0) clock_now = $urandom;
        else clock_now += $urandom_range(0, 60);
        time_update(clock_now);
      end
    end
  endtask

  initial begin : stimulus
    sb              = new();
    in_ch.valid     = 1'b0;
    in_ch.req_type  = ttcs_pkg::REQ_PUSH;
    in_ch.char_code = '0;
    in_ch.now_ticks = '0;
    cfg_we          = 1'b0;
    cfg_idx         = ttcs_pkg::REG_LINE_LENGTH;
    cfg_wdata       = '0;
    in_gap_max      = 5;
    out_gap_max     = 5;
    hold_cycles     = 0;
    clock_now       = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: time zero on an empty queue, then a short line of text
    time_update(32'd0);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(8'h55);
    push_char(8'hAA);
    time_update(32'd5);
    push_char(8'h81);
    push_char(8'h7E);

    // line length zero and pitch zero; the column is already past the line
    set_regs(6'd0, 8'd0, 32'd0, 32'd0);
    time_update(32'd9);
    time_update(32'd9);
    time_update(32'd9);

    // start a long scroll, then lower the pitch below the current offset
    set_regs(6'd1, 8'd255, 32'd0, 32'd10);
    push_char(8'hC3);
    time_update(32'd100);
    time_update(32'd59);
    set_regs(6'd1, 8'd2, 32'd0, 32'd10);
    time_update(32'd69);

    // maximum tick costs, line length above range, time going backwards
    set_regs(6'h3F, 8'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_char(8'h3C);
    time_update(sb.saved_time - 32'd1);
    time_update(sb.saved_time - 32'd1000);

    // hold off the result side for a long stretch while pushes keep coming
    set_regs(6'd48, 8'd3, 32'hFFFF_FFFF, 32'd0);
    in_gap_max  = 0;
    out_gap_max = 0;
    hold_cycles = 300;
    repeat (24) push_char(CharW'($urandom));
    set_regs(6'd48, 8'd3, 32'd0, 32'd0);
    clock_now = sb.saved_time;
    while (sb.held_chars.size() > 0) begin
      clock_now += $urandom_range(0, 9);
      time_update(clock_now);
    end

    random_phase(15, 6'd1, 8'd1, 32'd0, 32'd0);
    random_phase(15, 6'd48, 8'd255, 32'd1, 32'd0);
    random_phase(15, ColW'($urandom_range(1, 48)), PitchW'($urandom_range(1, 12)),
                 $urandom_range(0, 20), $urandom_range(0, 6));
    random_phase(15, 6'h3F, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(15, ColW'($urandom_range(1, 48)), PitchW'($urandom_range(1, 12)),
                 $urandom_range(0, 20), $urandom_range(0, 6));
    random_phase(15, ColW'($urandom_range(1, 8)), PitchW'($urandom_range(1, 255)),
                 $urandom_range(0, 4), $urandom_range(0, 2));

    wait_drained();
    if (sb.failures == 0) begin
      $display("** timed_text_console_scroller_core: PASSED **");
    end else begin
      $display("** timed_text_console_scroller_core: FAILED **");
    end
    $finish;
  end

endmodule
